[hdl/csvs_pkg.sv]
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared types and constants for the CSV line field splitter.
// ----------------------------------------------------------------------------
package csvs_pkg;

  localparam int unsigned MaxFields  = 1024;
  localparam int unsigned FieldW     = 10;
  localparam int unsigned FieldTopI  = (MaxFields - 1 < 1023) ? MaxFields - 1 : 1023;
  localparam logic [FieldW-1:0] FieldTop = FieldW'(FieldTopI);

  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = FifoPtrW + 1;

  localparam int unsigned CfgIdxW    = 2;
  localparam logic [CfgIdxW-1:0] CFG_DELIMITER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ENCLOSURE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE    = 2'd2;

  localparam logic [7:0] DelimiterRst = 8'd44;
  localparam logic [7:0] EnclosureRst = 8'd34;
  localparam logic [7:0] EscapeRst    = 8'd92;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_FIELD   = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    MODE_OUTSIDE     = 4'b0001,
    MODE_INSIDE      = 4'b0010,
    MODE_ESC_PENDING = 4'b0100,
    MODE_ENC_PENDING = 4'b1000
  } mode_e;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data;
    logic [FieldW-1:0] fnum;
    logic              done;
    logic              last;
  } res_t;

  // one accepted item: one or two results
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } item_t;

endpackage

[hdl/csvs_front.sv]
// ----------------------------------------------------------------------------
// csvs_front
// Accepts line beats, runs the quote/escape parser and builds result pairs.
// ----------------------------------------------------------------------------
module csvs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   line_byte_i,
  input  logic                         byte_present_i,
  input  logic                         line_end_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [csvs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output csvs_pkg::item_t              q_item_o
);
  import csvs_pkg::*;

  logic [7:0]        delim_q, enc_q, esc_q;
  mode_e             mode_q, mode_m, mode_d;
  logic [FieldW-1:0] cnt_q, cnt_m, cnt_d;
  logic              accept, is_out;
  logic              b_v, e1_v;
  res_t              b_res, e0_res, e1_res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DelimiterRst;
      enc_q   <= EnclosureRst;
      esc_q   <= EscapeRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DELIMITER: delim_q <= cfg_data_i;
        CFG_ENCLOSURE: enc_q   <= cfg_data_i;
        CFG_ESCAPE:    esc_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // byte step
  always_comb begin
    mode_m = mode_q;
    cnt_m  = cnt_q;
    b_v    = 1'b0;
    is_out = 1'b0;
    b_res  = '0;
    b_res.kind = KIND_DATA;
    b_res.fnum = cnt_q;
    b_res.data = line_byte_i;
    if (byte_present_i) begin
      case (mode_q)
        MODE_INSIDE: begin
          if (line_byte_i == esc_q) begin
            mode_m = MODE_ESC_PENDING;
          end else if (line_byte_i == enc_q) begin
            mode_m = MODE_ENC_PENDING;
          end else begin
            b_v = 1'b1;
          end
        end
        MODE_ESC_PENDING: begin
          b_v    = 1'b1;
          mode_m = MODE_INSIDE;
        end
        MODE_ENC_PENDING: begin
          if (line_byte_i == enc_q) begin
            b_v    = 1'b1;
            mode_m = MODE_INSIDE;
          end else begin
            mode_m = MODE_OUTSIDE;
            is_out = 1'b1;
          end
        end
        default: is_out = 1'b1;
      endcase
      if (is_out) begin
        if (line_byte_i == delim_q) begin
          b_v        = 1'b1;
          b_res.kind = KIND_FIELD;
          b_res.data = '0;
          if (cnt_q < FieldTop) cnt_m = cnt_q + FieldW'(1);
        end else if (line_byte_i == enc_q) begin
          mode_m = MODE_INSIDE;
        end else begin
          b_v = 1'b1;
        end
      end
    end
  end

  // line end step
  always_comb begin
    mode_d = mode_m;
    cnt_d  = cnt_m;
    e1_v   = 1'b0;
    e0_res = '0;
    e1_res = '0;
    e0_res.fnum = cnt_m;
    e1_res.fnum = cnt_m;
    e0_res.done = 1'b1;
    e0_res.kind = KIND_FIELD;
    e1_res.kind = KIND_DISCARD;
    e1_res.done = 1'b1;
    case (mode_m)
      MODE_INSIDE: e0_res.kind = KIND_DISCARD;
      MODE_ESC_PENDING: begin
        if (esc_q != enc_q) begin
          e0_res.kind = KIND_DATA;
          e0_res.data = esc_q;
          e0_res.done = 1'b0;
          e1_v        = 1'b1;
        end
      end
      default: ;
    endcase
    if (line_end_i) begin
      mode_d = MODE_OUTSIDE;
      cnt_d  = '0;
    end
  end

  always_comb begin
    q_item_o     = '0;
    q_item_o.two = (b_v && line_end_i) || (line_end_i && e1_v);
    q_item_o.r0  = b_v ? b_res : e0_res;
    q_item_o.r1  = b_v ? e0_res : e1_res;
    if (q_item_o.two) q_item_o.r1.last = 1'b1;
    else              q_item_o.r0.last = 1'b1;
  end

  assign q_push_o = accept && (b_v || line_end_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OUTSIDE;
      cnt_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && line_end_i |=> mode_q == MODE_OUTSIDE && cnt_q == '0)
    else $error("parser state not cleared after line end");
  a_inside_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !line_end_i && mode_q == MODE_INSIDE |=> cnt_q == $past(cnt_q))
    else $error("field count moved inside quotes");
`endif

endmodule

[hdl/csvs_fifo.sv]
// ----------------------------------------------------------------------------
// csvs_fifo
// Short queue of result pairs between the parser and the output stage.
// ----------------------------------------------------------------------------
module csvs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  csvs_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output csvs_pkg::item_t head_o
);
  import csvs_pkg::*;

  item_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoCntW-1:0] cnt_q;

  assign full_o  = cnt_q == FifoCntW'(FifoDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + FifoPtrW'(1);
      if (pop_i)  rd_q <= rd_q + FifoPtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + FifoCntW'(1);
        2'b01:   cnt_q <= cnt_q - FifoCntW'(1);
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
`endif

endmodule

[hdl/csvs_back.sv]
// ----------------------------------------------------------------------------
// csvs_back
// Drains queued result pairs one beat at a time into the output register.
// ----------------------------------------------------------------------------
module csvs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  csvs_pkg::item_t             head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  result_kind_o,
  output logic [7:0]                  out_byte_o,
  output logic [csvs_pkg::FieldW-1:0] field_number_o,
  output logic                        line_done_o,
  output logic                        last_of_item_o
);
  import csvs_pkg::*;

  logic valid_q, sel_q, sel_d, load;
  res_t res_q, pick;

  assign load  = !empty_i && (!valid_q || !out_stall_i);
  assign pick  = sel_q ? head_i.r1 : head_i.r0;
  assign pop_o = load && (sel_q || !head_i.two);

  always_comb begin
    sel_d = sel_q;
    if (load) sel_d = !pop_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      sel_q <= sel_d;
      if (load) valid_q <= 1'b1;
      else if (!out_stall_i) valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= pick;
  end

  assign out_valid_o    = valid_q;
  assign result_kind_o  = res_q.kind;
  assign out_byte_o     = res_q.data;
  assign field_number_o = res_q.fnum;
  assign line_done_o    = res_q.done;
  assign last_of_item_o = res_q.last;

`ifndef ASSERT_OFF
  a_discard_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.kind == KIND_DISCARD |-> res_q.done && res_q.last)
    else $error("discard beat not closing the line");
`endif

endmodule

[hdl/csv_line_field_splitter_core.sv]
// Path: an accepted beat's results enter the result queue, then the output register.
// Throughput: one line beat per cycle unless the result queue is full; the output
//   gives one result per cycle when not stalled; two results leave one by one.
// A four-entry result queue decouples the parser from the output register.
// Reset: asynchronous, active low; clears parser mode, field count and queue,
//   and loads the delimiter, enclosure and escape registers with their defaults.
// ----------------------------------------------------------------------------
// csv_line_field_splitter_core
// Byte-serial CSV line splitter: parser front end, result queue, output stage.
// ----------------------------------------------------------------------------
module csv_line_field_splitter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   line_byte_i,
  input  logic                         byte_present_i,
  input  logic                         line_end_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [csvs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   result_kind_o,
  output logic [7:0]                   out_byte_o,
  output logic [csvs_pkg::FieldW-1:0]  field_number_o,
  output logic                         line_done_o,
  output logic                         last_of_item_o
);
  import csvs_pkg::*;

  logic  q_full, q_push, q_pop, q_empty;
  item_t q_in, q_head;

  csvs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .line_byte_i    (line_byte_i),
    .byte_present_i (byte_present_i),
    .line_end_i     (line_end_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (q_in)
  );

  csvs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  csvs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .out_byte_o     (out_byte_o),
    .field_number_o (field_number_o),
    .line_done_o    (line_done_o),
    .last_of_item_o (last_of_item_o)
  );

endmodule
